// File: rtl/rbsi_pkg.sv
// rbsi_pkg: shared types and constants of the ray against box slab test
// no dependencies; used by rbsi_div and ray_box_slab_intersect_top
package rbsi_pkg;

    // coordinate width of origin, direction and center fields
    localparam int COORD_WIDTH = 32;
    localparam int EXT_W       = COORD_WIDTH - 1;
    // signed width of (bound - origin)
    localparam int DIFF_W      = COORD_WIDTH + 3;
    // magnitude width of the numerator and the divisor
    localparam int NUM_W       = COORD_WIDTH + 1;
    localparam int DEN_W       = COORD_WIDTH;
    // quotient bits of (num << 16) / den, one per divider stage
    localparam int FRAC_W      = 16;
    localparam int QUO_W       = NUM_W + FRAC_W;
    // signed time width
    localparam int TIME_W      = QUO_W + 1;
    localparam int THR_W       = 16;
    localparam int ENTRY_W     = 32;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
    localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {QUO_W{1'b1}}};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic [EXT_W-1:0]              extent_x;
        logic [EXT_W-1:0]              extent_y;
        logic [EXT_W-1:0]              extent_z;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] entry_t;
    } t_resp;

    // per-axis flags that travel beside the dividers
    typedef struct packed {
        logic [2:0] act;
        logic [2:0] out_miss;
        logic [2:0] neg_lo;
        logic [2:0] neg_hi;
    } t_side;

endpackage

// File: rtl/rbsi_div.sv
// rbsi_div: pipelined restoring divider, one quotient bit per stage
// computes (num << FRAC_W) / den; depends on rbsi_pkg
module rbsi_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rbsi_pkg::NUM_W-1:0]    i_num,
    input  logic [rbsi_pkg::DEN_W-1:0]    i_den,
    output logic [rbsi_pkg::QUO_W-1:0]    o_quo
);
    localparam int QW = rbsi_pkg::QUO_W;
    localparam int DW = rbsi_pkg::DEN_W;

    logic [QW-1:0] r_n [QW];
    logic [DW-1:0] r_r [QW];
    logic [DW-1:0] r_d [QW];
    logic [QW-1:0] r_q [QW];
    logic [QW-1:0] n_n [QW];
    logic [DW-1:0] n_r [QW];
    logic [DW-1:0] n_d [QW];
    logic [QW-1:0] n_q [QW];

    // one trial subtract per stage
    always_comb begin
        logic [QW-1:0] s_n;
        logic [DW-1:0] s_r;
        logic [DW-1:0] s_d;
        logic [QW-1:0] s_q;
        logic [DW:0]   trial;
        logic          ge;
        for (int s = 0; s < QW; s++) begin
            if (s == 0) begin
                s_n = {i_num, {rbsi_pkg::FRAC_W{1'b0}}};
                s_r = '0;
                s_d = i_den;
                s_q = '0;
            end else begin
                s_n = r_n[s-1];
                s_r = r_r[s-1];
                s_d = r_d[s-1];
                s_q = r_q[s-1];
            end
            trial  = {s_r, s_n[QW-1]};
            ge     = (trial >= {1'b0, s_d});
            n_r[s] = ge ? DW'(trial - {1'b0, s_d}) : DW'(trial);
            n_n[s] = {s_n[QW-2:0], 1'b0};
            n_d[s] = s_d;
            n_q[s] = {s_q[QW-2:0], ge};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_n[s] <= n_n[s];
                r_r[s] <= n_r[s];
                r_d[s] <= n_d[s];
                r_q[s] <= n_q[s];
            end
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

// File: rtl/ray_box_slab_intersect_top.sv
// ray_box_slab_intersect_top: ray against axis-aligned box, slab method
// depends on rbsi_pkg and rbsi_div
//
// Usage:
//   request channel i_valid/o_ready/i_req carries one ray and one box.
//   response channel o_valid/i_ready/o_resp returns hit and entry time.
//   config channel i_cfg_valid/o_cfg_ready/i_cfg_data writes the parallel
//   threshold; it is always ready and should be written while idle.
// Throughput: one request per cycle when not stalled, set by the six
//   bit-per-stage dividers that run side by side.
// Pipeline: the input register loads at the accepting edge, followed by
//   slab prep, 49 divider stages, sort, and the fold into the output
//   register that raises response valid.
// Reset: synchronous active-low; all valid bits clear and the threshold
//   returns to 1.
// Stall: when the output register holds a response that is not taken,
//   the whole pipeline freezes and o_ready drops; nothing is lost.
module ray_box_slab_intersect_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  rbsi_pkg::t_req              i_req,
    output logic                        o_valid,
    input  logic                        i_ready,
    output rbsi_pkg::t_resp             o_resp,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rbsi_pkg::THR_W-1:0]  i_cfg_data
);
    localparam int CW = rbsi_pkg::COORD_WIDTH;
    localparam int XW = rbsi_pkg::DIFF_W;
    localparam int NW = rbsi_pkg::NUM_W;
    localparam int DW = rbsi_pkg::DEN_W;
    localparam int QW = rbsi_pkg::QUO_W;
    localparam int TW = rbsi_pkg::TIME_W;

    logic en;
    logic [rbsi_pkg::THR_W-1:0] r_thr;

    logic           r_v1;
    rbsi_pkg::t_req r_req;
    logic           r_v2;
    rbsi_pkg::t_side r_side2;
    logic [NW-1:0]  r_num [6];
    logic [DW-1:0]  r_den [3];
    logic [QW-1:0]  quo [6];
    logic           r_vd [QW];
    rbsi_pkg::t_side r_sd [QW];
    logic           r_v3;
    logic [2:0]     r_act3;
    logic           r_miss3;
    logic signed [TW-1:0] r_tlo [3];
    logic signed [TW-1:0] r_thi [3];
    logic           r_vo;
    rbsi_pkg::t_resp r_resp;

    assign en          = !r_vo || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vo;
    assign o_resp      = r_resp;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rbsi_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
            for (int s = 0; s < QW; s++) r_vd[s] <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_vd[0] <= r_v2;
            for (int s = 1; s < QW; s++) r_vd[s] <= r_vd[s-1];
            r_v3 <= r_vd[QW-1];
            r_vo <= r_v3;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (en) r_req <= i_req;
    end

    // slab prep: differences, magnitudes, parallel and outside flags
    logic signed [CW-1:0] ax_o [3];
    logic signed [CW-1:0] ax_d [3];
    logic signed [CW-1:0] ax_c [3];
    logic [CW-2:0]        ax_e [3];
    assign ax_o[0] = r_req.origin_x;
    assign ax_o[1] = r_req.origin_y;
    assign ax_o[2] = r_req.origin_z;
    assign ax_d[0] = r_req.dir_x;
    assign ax_d[1] = r_req.dir_y;
    assign ax_d[2] = r_req.dir_z;
    assign ax_c[0] = r_req.center_x;
    assign ax_c[1] = r_req.center_y;
    assign ax_c[2] = r_req.center_z;
    assign ax_e[0] = r_req.extent_x;
    assign ax_e[1] = r_req.extent_y;
    assign ax_e[2] = r_req.extent_z;

    rbsi_pkg::t_side n_side2;
    logic [NW-1:0]   n_num [6];
    logic [DW-1:0]   n_den [3];

    always_comb begin
        logic signed [XW-1:0] o;
        logic signed [XW-1:0] c;
        logic signed [XW-1:0] e;
        logic signed [XW-1:0] dlo;
        logic signed [XW-1:0] dhi;
        logic signed [XW-1:0] mlo;
        logic signed [XW-1:0] mhi;
        logic [DW-1:0]        ad;
        logic                 par;
        logic                 dneg;
        for (int a = 0; a < 3; a++) begin
            o    = XW'(ax_o[a]);
            c    = XW'(ax_c[a]);
            e    = $signed({{(XW-CW+1){1'b0}}, ax_e[a]});
            dlo  = c - e - o;
            dhi  = c + e - o;
            dneg = ax_d[a][CW-1];
            ad   = dneg ? DW'(-ax_d[a]) : DW'(ax_d[a]);
            par  = (ax_d[a] == '0) || (ad < DW'(r_thr));
            mlo  = dlo[XW-1] ? -dlo : dlo;
            mhi  = dhi[XW-1] ? -dhi : dhi;
            n_num[2*a]         = NW'(mlo);
            n_num[2*a+1]       = NW'(mhi);
            n_den[a]           = ad;
            n_side2.act[a]      = !par;
            n_side2.out_miss[a] = par && ((dlo > 0) || (dhi < 0));
            n_side2.neg_lo[a]   = dlo[XW-1] != dneg;
            n_side2.neg_hi[a]   = dhi[XW-1] != dneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side2 <= n_side2;
            for (int k = 0; k < 6; k++) r_num[k] <= n_num[k];
            for (int a = 0; a < 3; a++) r_den[a] <= n_den[a];
        end
    end

    // six crossing-time dividers
    for (genvar k = 0; k < 6; k++) begin : g_div
        rbsi_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num[k]),
            .i_den (r_den[k/2]),
            .o_quo (quo[k])
        );
    end

    // flags ride beside the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_side2;
            for (int s = 1; s < QW; s++) r_sd[s] <= r_sd[s-1];
        end
    end

    // apply signs and order each axis's crossing times
    always_ff @(posedge i_clk) begin
        logic signed [TW-1:0] t1;
        logic signed [TW-1:0] t2;
        if (en) begin
            r_act3  <= r_sd[QW-1].act;
            r_miss3 <= |r_sd[QW-1].out_miss;
            for (int a = 0; a < 3; a++) begin
                t1 = $signed({1'b0, quo[2*a]});
                t2 = $signed({1'b0, quo[2*a+1]});
                if (r_sd[QW-1].neg_lo[a]) t1 = -t1;
                if (r_sd[QW-1].neg_hi[a]) t2 = -t2;
                r_tlo[a] <= (t1 > t2) ? t2 : t1;
                r_thi[a] <= (t1 > t2) ? t1 : t2;
            end
        end
    end

    // fold the axes into entry and exit, form the response
    always_ff @(posedge i_clk) begin
        logic signed [TW-1:0] tmin;
        logic signed [TW-1:0] tmax;
        logic                 miss;
        if (en) begin
            tmin = '0;
            tmax = rbsi_pkg::TIME_MAX;
            for (int a = 0; a < 3; a++) begin
                if (r_act3[a]) begin
                    if (r_tlo[a] > tmin) tmin = r_tlo[a];
                    if (r_thi[a] < tmax) tmax = r_thi[a];
                end
            end
            miss = r_miss3 || (tmin > tmax);
            r_resp.hit <= !miss;
            if (miss) begin
                r_resp.entry_t <= '0;
            end else if (tmin > $signed(TW'({rbsi_pkg::ENTRY_W{1'b1}}))) begin
                r_resp.entry_t <= '1;
            end else begin
                r_resp.entry_t <= tmin[rbsi_pkg::ENTRY_W-1:0];
            end
        end
    end

    // checks
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_resp.hit |-> o_resp.entry_t == '0)
        else $error("miss with nonzero entry time");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted request not captured");
    a_thr_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_thr == rbsi_pkg::THR_RESET)
        else $error("threshold not reset");

endmodule

// File: tb/ray_box_slab_intersect_top_tb.sv
// ray_box_slab_intersect_top_tb: self-checking bench for the ray against box slab test
// depends on rbsi_pkg and ray_box_slab_intersect_top; a directed table, then random
// requests under several parallel thresholds, checked against a local slab predictor
module ray_box_slab_intersect_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SLAB_T_LIM = (longint'(1) << 56) - 1;
    localparam int     PIPE_DEPTH = rbsi_pkg::QUO_W + 4;
    localparam int     REQ_W      = $bits(rbsi_pkg::t_req);

    typedef struct {
        rbsi_pkg::t_req  req;
        bit              typed;
        rbsi_pkg::t_resp want;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    rbsi_pkg::t_req             i_req = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    rbsi_pkg::t_resp            o_resp;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [rbsi_pkg::THR_W-1:0] i_cfg_data = '0;

    // predictor copy of the threshold register
    int               thr_shadow = 1;
    rbsi_pkg::t_resp  hit_q[$];
    int               err_cnt = 0;
    int               req_cnt = 0;
    int               hit_cnt = 0;
    int               miss_cnt = 0;
    bit               no_idle = 1'b0;

    ray_box_slab_intersect_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_resp(o_resp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // crossing time (num << 16) / den, truncated toward zero and saturated
    function automatic longint slab_cross(longint num, longint den);
        bit     neg;
        longint un, ud, q, r, m;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = un / ud;
        r = un % ud;
        m = (q << 16) + ((r << 16) / ud);
        if (m > SLAB_T_LIM) m = SLAB_T_LIM;
        return neg ? -m : m;
    endfunction

    // slab walk over x, y, z with running entry and exit times
    function automatic rbsi_pkg::t_resp slab_predict(rbsi_pkg::t_req r);
        longint o[3], d[3], c[3], e[3];
        longint lo, hi, ad, t1, t2, s, tmin, tmax;
        bit     hit;
        rbsi_pkg::t_resp res;
        o = '{r.origin_x, r.origin_y, r.origin_z};
        d = '{r.dir_x, r.dir_y, r.dir_z};
        c = '{r.center_x, r.center_y, r.center_z};
        e = '{longint'({1'b0, r.extent_x}), longint'({1'b0, r.extent_y}),
              longint'({1'b0, r.extent_z})};
        tmin = 0;
        tmax = SLAB_T_LIM;
        hit = 1'b1;
        for (int a = 0; a < 3 && hit; a++) begin
            lo = c[a] - e[a];
            hi = c[a] + e[a];
            ad = d[a] < 0 ? -d[a] : d[a];
            if (d[a] == 0 || ad < thr_shadow) begin
                if (o[a] < lo || o[a] > hi) hit = 1'b0;
            end else begin
                t1 = slab_cross(lo - o[a], d[a]);
                t2 = slab_cross(hi - o[a], d[a]);
                if (t1 > t2) begin
                    s = t1;
                    t1 = t2;
                    t2 = s;
                end
                if (t1 > tmin) tmin = t1;
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax) hit = 1'b0;
            end
        end
        res.hit = hit;
        if (!hit) res.entry_t = '0;
        else if (tmin > 64'hFFFF_FFFF) res.entry_t = '1;
        else res.entry_t = tmin[rbsi_pkg::ENTRY_W-1:0];
        return res;
    endfunction

    function automatic rbsi_pkg::t_req mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                              int cx, int cy, int cz, int ex, int ey, int ez);
        rbsi_pkg::t_req r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        r.center_x = cx; r.center_y = cy; r.center_z = cz;
        r.extent_x = ex[rbsi_pkg::EXT_W-1:0];
        r.extent_y = ey[rbsi_pkg::EXT_W-1:0];
        r.extent_z = ez[rbsi_pkg::EXT_W-1:0];
        return r;
    endfunction

    function automatic int srand_span(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // direction component: zero, around the threshold, toward the box, or anything
    function automatic int pick_dir(int toward);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return thr_shadow > 0 ? thr_shadow - 1 : 0;
            2: return $urandom_range(0, 1) ? thr_shadow : -thr_shadow;
            3: return $urandom;
            default: return (toward >>> $urandom_range(0, 8)) + srand_span(256);
        endcase
    endfunction

    // random ray and box; mostly small scenes aimed near the box
    function automatic rbsi_pkg::t_req rand_ray();
        rbsi_pkg::t_req r;
        int   o[3], c[3], e[3], d[3];
        if ($urandom_range(0, 9) < 2) begin
            r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            return r;
        end
        for (int a = 0; a < 3; a++) begin
            c[a] = srand_span(1 << 22);
            e[a] = $urandom_range(0, 1 << 21);
            o[a] = c[a] + srand_span(1 << 23);
            d[a] = pick_dir(c[a] - o[a]);
        end
        return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2], c[0], c[1], c[2],
                      e[0], e[1], e[2]);
    endfunction

    // send one request, with an optional random gap before it
    task automatic send_ray(rbsi_pkg::t_req r, bit typed, rbsi_pkg::t_resp want);
        bit acc;
        if (!no_idle && $urandom_range(0, 99) < 34) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= r;
        do begin
            @(negedge i_clk);
            acc = o_ready;
            @(posedge i_clk);
        end while (!acc);
        hit_q.push_back(typed ? want : slab_predict(r));
        req_cnt++;
    endtask

    task automatic wait_drained();
        while (hit_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_thr(int v);
        bit acc;
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v[rbsi_pkg::THR_W-1:0];
        do begin
            @(negedge i_clk);
            acc = o_cfg_ready;
            @(posedge i_clk);
        end while (!acc);
        i_cfg_valid <= 1'b0;
        thr_shadow = v & 16'hFFFF;
    endtask

    // response side: random stalls, check at negedge for the coming edge
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= no_idle || ($urandom_range(0, 99) >= 34);
    end

    always @(negedge i_clk) begin
        rbsi_pkg::t_resp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (hit_q.size() == 0) begin
                $display("%0t: response with none pending: got hit=%0b entry=%h",
                         $realtime, o_resp.hit, o_resp.entry_t);
                err_cnt++;
            end else begin
                want = hit_q.pop_front();
                if (o_resp.hit !== want.hit) begin
                    $display("%0t: hit mismatch: expected %0b, got %0b",
                             $realtime, want.hit, o_resp.hit);
                    err_cnt++;
                end
                if (o_resp.entry_t !== want.entry_t) begin
                    $display("%0t: entry_t mismatch: expected %h, got %h",
                             $realtime, want.entry_t, o_resp.entry_t);
                    err_cnt++;
                end
                if (want.hit) hit_cnt++;
                else miss_cnt++;
            end
        end
    end

    initial begin
        #5ms;
        $display("ray_box_slab_intersect_top test failed");
        $finish;
    end

    initial begin
        t_row            rows[$];
        rbsi_pkg::t_resp none;
        int              thr_list[5];
        none = '0;
        // directed table; typed expectations where obvious
        rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 'h10000, 'h10000, 'h10000),
                         1, '{1'b1, 32'h0}});
        rows.push_back('{mk_ray('h50000, 0, 0, 0, 0, 0, 0, 0, 0, 'h10000, 'h10000, 'h10000),
                         1, '{1'b0, 32'h0}});
        // origin on the slab boundary is inside
        rows.push_back('{mk_ray('h10000, -'h10000, 0, 0, 0, 0, 0, 0, 0,
                                'h10000, 'h10000, 0), 1, '{1'b1, 32'h0}});
        rows.push_back('{mk_ray(-'ha0000, 0, 0, 'h10000, 0, 0, 0, 0, 0,
                                'h10000, 'h10000, 'h10000), 1, '{1'b1, 32'h90000}});
        // box behind the ray
        rows.push_back('{mk_ray('ha0000, 0, 0, 'h10000, 0, 0, 0, 0, 0,
                                'h10000, 'h10000, 'h10000), 1, none});
        // huge entry saturates the output
        rows.push_back('{mk_ray(32'h8000_0000, 0, 0, 1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0),
                         1, '{1'b1, 32'hFFFF_FFFF}});
        // diagonal rays in the xy plane, first against a box of zero y extent
        rows.push_back('{mk_ray(-'h20000, -'h20000, 0, 'h10000, 'h10000, 0, 0, 0, 0,
                                'h10000, -'h10000 & 'h0, 'h10000), 0, none});
        rows.push_back('{mk_ray(-'h20000, -'h30000, 0, 'h10000, 'h10000, 0, 0, 0, 0,
                                'h10000, 'h10000, 'h10000), 0, none});
        // direction at and just under the threshold
        rows.push_back('{mk_ray(-'h20000, 0, 0, 1, 0, 0, 0, 0, 0, 'h10000, 1, 1), 0, none});
        rows.push_back('{mk_ray(-'h20000, 0, 0, 0, 1, 0, 0, 0, 0, 'h10000, 1, 1), 0, none});
        rows.push_back('{mk_ray(-'h20000, 'h5, 'h7, -'h30000, 'h20000, -1, 'h8000, -'h8000,
                                'h100, 'h18000, 'h9000, 'h300), 0, none});
        // field extremes
        rows.push_back('{'{origin_x: 32'h7FFF_FFFF, origin_y: 32'h8000_0000,
                           origin_z: 32'h7FFF_FFFF, dir_x: 32'h8000_0000,
                           dir_y: 32'h7FFF_FFFF, dir_z: 32'h8000_0000,
                           center_x: 32'h8000_0000, center_y: 32'h7FFF_FFFF,
                           center_z: 32'h8000_0000, extent_x: '1, extent_y: '1,
                           extent_z: '1}, 0, none});
        rows.push_back('{'{origin_x: 32'h8000_0000, origin_y: 32'h8000_0000,
                           origin_z: 32'h8000_0000, dir_x: 32'h7FFF_FFFF,
                           dir_y: 32'h7FFF_FFFF, dir_z: 32'h7FFF_FFFF,
                           center_x: 32'h7FFF_FFFF, center_y: 32'h7FFF_FFFF,
                           center_z: 32'h7FFF_FFFF, extent_x: '1, extent_y: '1,
                           extent_z: '1}, 0, none});
        rows.push_back('{'{default: '1}, 0, none});
        rows.push_back('{'{default: '0}, 0, none});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_ray(rows[k].req, rows[k].typed, rows[k].want);
        for (int k = 0; k < 100; k++) begin
            send_ray(rand_ray(), 0, none);
            if (k == 50) begin
                // hold off until the pipe is empty
                i_valid <= 1'b0;
                wait_drained();
            end
        end
        i_valid <= 1'b0;
        wait_drained();

        // threshold sweep including both extremes
        thr_list = '{1, 0, 65535, $urandom_range(2, 65534), $urandom_range(2, 300)};
        foreach (thr_list[p]) begin
            write_thr(thr_list[p]);
            no_idle = (p == 2);
            for (int k = 0; k < 100; k++) send_ray(rand_ray(), 0, none);
            i_valid <= 1'b0;
            wait_drained();
            no_idle = 1'b0;
        end

        $display("sent %0d rays over %0d threshold settings: %0d hits, %0d misses",
                 req_cnt, 6, hit_cnt, miss_cnt);
        if (err_cnt == 0) begin
            $display("ray_box_slab_intersect_top test passed");
        end else begin
            $display("ray_box_slab_intersect_top test failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/rbsi_pkg.sv
rtl/rbsi_div.sv
rtl/ray_box_slab_intersect_top.sv
tb/ray_box_slab_intersect_top_tb.sv
